/* hdl/hdt_pkg.sv */
`default_nettype none

package hdt_pkg;

    localparam int WORD_W = 64;
    localparam int POP_W  = 7;
    localparam int DIST_W = 13;
    localparam int THR_W  = 13;

    typedef struct packed {
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic              last_word;
    } t_in_word;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              is_near;
    } t_out_word;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [POP_W-1:0] pop;
    } t_step;

endpackage

`default_nettype wire

/* hdl/hdt_popcnt.sv */
`default_nettype none

module hdt_popcnt
    import hdt_pkg::*;
(
    input  wire logic [WORD_W-1:0] i_bits,
    output logic      [POP_W-1:0]  o_count
);

    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];

    always_comb begin
        for (int i = 0; i < 32; i++) begin
            l1[i] = {1'b0, i_bits[2*i]} + {1'b0, i_bits[2*i+1]};
        end
        for (int i = 0; i < 16; i++) begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        end
        o_count = {1'b0, l5[0]} + {1'b0, l5[1]};
    end

endmodule

`default_nettype wire

/* hdl/hdt_accum.sv */
`default_nettype none

module hdt_accum
    import hdt_pkg::*;
#(
    parameter int MAX_BITS = 4096
)
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_step            i_step,
    input  wire logic [THR_W-1:0] i_threshold,
    output logic                  o_advance,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_out_word             o_word
);

    localparam int CNT_W = $clog2(MAX_BITS + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;
    localparam logic [SUM_W-1:0] SumMax = SUM_W'(MAX_BITS);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_word        r_out;
    t_out_word        n_out;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sat;
    logic [CMP_W-1:0] sat_ext;
    logic             step_en;

    assign o_advance = !r_out_valid || i_ready;
    assign step_en   = i_step.valid && o_advance;

    always_comb begin
        sum     = SUM_W'(r_count) + SUM_W'(i_step.pop);
        sat     = (sum > SumMax) ? SumMax : sum;
        sat_ext = CMP_W'(sat);

        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (step_en) begin
            if (i_step.last) begin
                n_count        = '0;
                n_out_valid    = 1'b1;
                n_out.distance = sat_ext[DIST_W-1:0];
                n_out.is_near  = (sat_ext <= CMP_W'(i_threshold));
            end else begin
                n_count = sat[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_count) <= SumMax)
        else $error("running count above maximum bit count");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_en && i_step.last |=> r_count == '0)
        else $error("running count not cleared after last word");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_en && !i_step.last |=> r_count >= $past(r_count))
        else $error("running count decreased within a comparison");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(step_en && i_step.last))
        else $error("result produced without a last word");

endmodule

`default_nettype wire

/* hdl/hamming_distance_threshold.sv */
`default_nettype none

// Channel  Direction  Handshake             Payload
// input    in         i_valid / o_ready     i_word  (word_a, word_b, last_word)
// result   out        o_valid / i_ready     o_word  (distance, is_near)
// config   in         i_cfg_we              i_cfg_wdata (near_threshold)
//
// One word pair is accepted every cycle while o_ready is high.
// The input register feeds the popcount tree and accumulator, which load the result register.
// The synchronous active-low reset clears the running count, threshold and valid flags.
// When the result register is full and not taken, the pipeline holds and o_ready drops
// once the input register is also occupied.

module hamming_distance_threshold
    import hdt_pkg::*;
#(
    parameter int MAX_BITS = 4096
)
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_in_word         i_word,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_out_word             o_word,
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_wdata
);

    logic             r_s1_valid;
    t_in_word         r_s1;
    logic [THR_W-1:0] r_threshold;
    logic [POP_W-1:0] pop;
    logic             advance;
    t_step            step;

    assign o_ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_threshold <= '0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1 <= i_word;
        end
    end

    hdt_popcnt u_popcnt (
        .i_bits  (r_s1.word_a ^ r_s1.word_b),
        .o_count (pop)
    );

    always_comb begin
        step.valid = r_s1_valid;
        step.last  = r_s1.last_word;
        step.pop   = pop;
    end

    hdt_accum #(
        .MAX_BITS (MAX_BITS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_threshold (r_threshold),
        .o_advance   (advance),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word      (o_word)
    );

endmodule

`default_nettype wire

/* verif/hdt_result_checker.sv */
`default_nettype none

module hdt_result_checker
    import hdt_pkg::*;
#(
    parameter int MAX_BITS = 4096
)
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire t_in_word         i_in_word,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire t_out_word        i_out_word,
    input  wire logic             i_cfg_we,
    input  wire logic [THR_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [DIST_W-1:0] diff_count;
    logic [THR_W-1:0]  near_limit;
    t_out_word         distance_q[$];
    int                result_index;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        result_index = 0;
        diff_count   = '0;
        near_limit   = '0;
    end

    function automatic int count_set_bits(input logic [WORD_W-1:0] x);
        int n;
        n = 0;
        for (int k = 0; k < WORD_W; k++) begin
            n += int'(x[k]);
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR result %0d: %s is %0d, expected %0d", result_index, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        int        sum;
        t_out_word want;
        if (!i_rst_n) begin
            diff_count = '0;
            near_limit = '0;
            distance_q.delete();
        end else begin
            if (i_cfg_we) begin
                near_limit = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                sum = int'(diff_count) + count_set_bits(i_in_word.word_a ^ i_in_word.word_b);
                if (sum > MAX_BITS) begin
                    sum = MAX_BITS;
                end
                if (i_in_word.last_word) begin
                    want.distance = sum[DIST_W-1:0];
                    want.is_near  = (sum <= int'(near_limit));
                    distance_q    = {distance_q, want};
                    diff_count = '0;
                end else begin
                    diff_count = sum[DIST_W-1:0];
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (distance_q.size() == 0) begin
                    report_mismatch("unexpected word, distance", int'(i_out_word.distance), -1);
                end else begin
                    want = distance_q.pop_front();
                    if (i_out_word.distance !== want.distance) begin
                        report_mismatch("distance", int'(i_out_word.distance),
                                        int'(want.distance));
                    end
                    if (i_out_word.is_near !== want.is_near) begin
                        report_mismatch("is_near", int'(i_out_word.is_near), int'(want.is_near));
                    end
                end
                result_index++;
            end
        end
        o_pending <= distance_q.size();
    end

endmodule

`default_nettype wire

/* verif/tb_hamming_distance_threshold.sv */
`default_nettype none

module tb_hamming_distance_threshold;
    import hdt_pkg::*;

    localparam int MAX_BITS    = 4096;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 168;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    t_in_word         i_word;
    logic             o_valid;
    logic             i_ready;
    t_out_word        o_word;
    logic             i_cfg_we;
    logic [THR_W-1:0] i_cfg_wdata;

    int fail_count;
    int pending;
    int cycle_count;
    int tx_idle_pct;
    int rx_idle_pct;
    bit rx_hold_req;

    hamming_distance_threshold #(
        .MAX_BITS (MAX_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_word      (o_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    hdt_result_checker #(
        .MAX_BITS (MAX_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_word    (i_word),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_word   (o_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // The receiver either holds off for a long stretch on request or stalls at random.
    initial begin
        int hold_left;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_pair(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                             input logic last);
        t_in_word w;
        w.word_a    = a;
        w.word_b    = b;
        w.last_word = last;
        send_word(w);
    endtask

    function automatic t_in_word random_pair(input bit mostly_differ);
        t_in_word w;
        w.word_a    = {$urandom, $urandom};
        w.word_b    = {$urandom, $urandom};
        w.last_word = 1'b0;
        case ($urandom_range(9))
            0: w.word_b = w.word_a;
            1: w.word_b = ~w.word_a;
            2: w.word_b = w.word_a ^ (64'd1 << $urandom_range(WORD_W - 1));
            3: w.word_a = '0;
            4: w.word_b = '0;
            default: ;
        endcase
        if (mostly_differ && $urandom_range(9) != 0) begin
            w.word_b = ~w.word_a;
        end
        return w;
    endfunction

    task automatic send_comparison(input int n_words, input bit mostly_differ);
        t_in_word w;
        for (int k = 0; k < n_words; k++) begin
            w           = random_pair(mostly_differ);
            w.last_word = (k == n_words - 1);
            send_word(w);
        end
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_near_threshold(input logic [THR_W-1:0] value);
        wait_results_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [THR_W-1:0] threshold_for_phase(input int phase);
        case (phase)
            0: return '0;
            1: return '1;
            2: return THR_W'($urandom_range(400));
            3: return THR_W'(MAX_BITS);
            4: return THR_W'(MAX_BITS - 1);
            5: return THR_W'($urandom_range(8191));
            6: return THR_W'(1);
            7: return THR_W'($urandom_range(300));
            default: return THR_W'(128);
        endcase
    endfunction

    initial begin
        logic [WORD_W-1:0] ones;
        int                phase_words;
        int                pick;
        int                n_words;
        ones        = '1;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_word      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-word comparisons at the extremes, then zero padding of a shorter vector and a three-word comparison.
        send_pair('0, '0, 1'b1);
        send_pair(ones, '0, 1'b1);
        send_pair(ones, ones, 1'b1);
        send_pair('0, ones, 1'b1);
        send_pair(64'd1 << 63, '0, 1'b1);
        send_pair('0, 64'd1, 1'b1);
        send_pair(ones, '0, 1'b0);
        send_pair('0, '0, 1'b1);
        send_pair({32{2'b01}}, {32{2'b10}}, 1'b0);
        send_pair({32{2'b01}}, {32{2'b10}}, 1'b0);
        send_pair({32{2'b01}}, {32{2'b10}}, 1'b1);

        // Distances just below, at and just above the threshold.
        set_near_threshold(THR_W'(64));
        send_pair(ones, '0, 1'b1);
        send_pair(ones, '0, 1'b0);
        send_pair(64'd1, '0, 1'b1);
        send_pair(ones, 64'd1, 1'b1);

        for (int mode = 0; mode < 3; mode++) begin
            for (int sub = 0; sub < 3; sub++) begin
                set_near_threshold(threshold_for_phase(mode * 3 + sub));
                case (mode)
                    0: begin
                        tx_idle_pct = 27;
                        rx_idle_pct = 50;
                    end
                    1: begin
                        tx_idle_pct = 50;
                        rx_idle_pct = 27;
                    end
                    default: begin
                        tx_idle_pct = 0;
                        rx_idle_pct = 0;
                    end
                endcase
                if (sub == 0 && mode != 1) begin
                    rx_hold_req = 1'b1;
                end
                phase_words = 0;
                while (phase_words < PHASE_WORDS) begin
                    pick = $urandom_range(99);
                    if (pick < 5) begin
                        n_words = $urandom_range(72, 60);
                        send_comparison(n_words, 1'b1);
                    end else if (pick < 15) begin
                        n_words = $urandom_range(30, 9);
                        send_comparison(n_words, 1'b0);
                    end else begin
                        n_words = $urandom_range(8, 1);
                        send_comparison(n_words, 1'b0);
                    end
                    phase_words += n_words;
                end
            end
        end

        wait_results_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
